[src/bpss_pkg.sv]
`timescale 1ns / 1ps
package bpss_pkg;

  // Register indexes on the configuration channel
  localparam logic [2:0] CFG_BEACON_WAIT  = 3'd0;
  localparam logic [2:0] CFG_GUARD        = 3'd1;
  localparam logic [2:0] CFG_MEASURE_WAIT = 3'd2;
  localparam logic [2:0] CFG_SLOT         = 3'd3;
  localparam logic [2:0] CFG_BEACON_COUNT = 3'd4;

  // Register values after reset
  localparam logic [15:0] RST_BEACON_WAIT  = 16'd240;
  localparam logic [15:0] RST_GUARD        = 16'd1;
  localparam logic [15:0] RST_MEASURE_WAIT = 16'd30;
  localparam logic [15:0] RST_SLOT         = 16'd10;
  localparam logic [2:0]  RST_BEACON_COUNT = 3'd3;

  // Frame kinds on the result stream
  localparam logic FRAME_BEACON = 1'b0;
  localparam logic FRAME_POLL   = 1'b1;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_BEACON_WAIT = 3'd1,
    PH_GUARD       = 3'd2,
    PH_MEASURE     = 3'd3,
    PH_SLOT        = 3'd4,
    PH_SLOT_GUARD  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [15:0] beacon_wait;
    logic [15:0] guard;
    logic [15:0] measure_wait;
    logic [15:0] slot;
    logic [2:0]  beacon_count;
  } cfg_t;

endpackage

[src/bpss_cfg.sv]
`timescale 1ns / 1ps
module bpss_cfg
  import bpss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [2:0]  wr_addr_i,
  input  logic [15:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode one write transaction; unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_addr_i)
        CFG_BEACON_WAIT:  cfg_d.beacon_wait  = wr_data_i;
        CFG_GUARD:        cfg_d.guard        = wr_data_i;
        CFG_MEASURE_WAIT: cfg_d.measure_wait = wr_data_i;
        CFG_SLOT:         cfg_d.slot         = wr_data_i;
        CFG_BEACON_COUNT: cfg_d.beacon_count = wr_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beacon_wait  <= RST_BEACON_WAIT;
      cfg_q.guard        <= RST_GUARD;
      cfg_q.measure_wait <= RST_MEASURE_WAIT;
      cfg_q.slot         <= RST_SLOT;
      cfg_q.beacon_count <= RST_BEACON_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/beacon_poll_superframe_sequencer.sv]
`timescale 1ns / 1ps
// Superframe sequencer: one input transaction per cycle when not stalled, each one tick when
// advance is set. A beacon or poll caused by a tick is offered on the result stream in the
// cycle after the input transaction; phase, tick counter and result register update at once.
// Throughput: one input transaction per cycle; the single result register takes a new result
// in the cycle the old one is taken and stalls the input only while full and not taken.
// Reset: asynchronous active low; superframe start, counters and masks clear, 240/1/30/10/3.
module beacon_poll_superframe_sequencer
  import bpss_pkg::*;
#(
  parameter int NODE_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [0] advance, [8:1] mask_in, [15:9] zero
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] frame_payload, [10:8] beacon_index, [15:11] zero
  output logic        m_axis_tuser_o,   // [0] frame_kind
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] LastSlotCount = 4'(NODE_SLOTS);

  cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  bpss_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [2:0]  beacons_q, beacons_d;
  logic [2:0]  slot_q, slot_d;
  logic [7:0]  node_mask_q, node_mask_d;
  logic [7:0]  shift_mask_q, shift_mask_d;

  logic        out_valid_q;
  logic        out_kind_q;
  logic [7:0]  out_payload_q;
  logic [2:0]  out_index_q;

  logic        in_fire;
  logic        tick;
  logic        advance;
  logic [7:0]  mask_in;

  assign advance         = s_axis_tdata_i[0];
  assign mask_in         = s_axis_tdata_i[8:1];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign tick            = in_fire && advance;

  // Superframe start folds into the first tick of the beacon wait
  phase_e      cur_phase;
  logic [15:0] cur_tick;
  logic [2:0]  cur_beacons;
  logic [2:0]  cur_slot;
  logic [7:0]  cur_node_mask;
  logic [7:0]  cur_shift_mask;

  always_comb begin
    cur_phase      = phase_q;
    cur_tick       = tick_q;
    cur_beacons    = beacons_q;
    cur_slot       = slot_q;
    cur_node_mask  = node_mask_q;
    cur_shift_mask = shift_mask_q;
    case (phase_q)
      PH_BEACON_WAIT, PH_GUARD, PH_MEASURE, PH_SLOT, PH_SLOT_GUARD: ;
      default: begin
        cur_phase      = PH_BEACON_WAIT;
        cur_tick       = '0;
        cur_beacons    = '0;
        cur_slot       = '0;
        cur_node_mask  = mask_in;
        cur_shift_mask = mask_in;
      end
    endcase
  end

  // Wait counter: a limit of zero ends on the first tick, as does counter wrap
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic        wait_end;
  logic [2:0]  beacons_inc;
  logic [2:0]  slot_inc;
  logic        beacons_done;
  logic        slots_done;

  always_comb begin
    case (cur_phase)
      PH_BEACON_WAIT: limit = cfg.beacon_wait;
      PH_GUARD:       limit = cfg.guard;
      PH_MEASURE:     limit = cfg.measure_wait;
      PH_SLOT:        limit = cfg.slot;
      PH_SLOT_GUARD:  limit = cfg.guard;
      default:        limit = cfg.beacon_wait;
    endcase
  end

  assign tick_inc     = cur_tick + 16'd1;
  assign wait_end     = (tick_inc >= limit) || (tick_inc == 16'd0);
  assign beacons_inc  = cur_beacons + 3'd1;
  assign slot_inc     = cur_slot + 3'd1;
  assign beacons_done = (beacons_inc >= cfg.beacon_count) || (beacons_inc == 3'd0);
  assign slots_done   = ({1'b0, cur_slot} + 4'd1) >= LastSlotCount;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (tick) begin
      phase_d = cur_phase;
      if (wait_end) begin
        case (cur_phase)
          PH_BEACON_WAIT: phase_d = PH_GUARD;
          PH_GUARD:       phase_d = beacons_done ? PH_MEASURE : PH_GUARD;
          PH_MEASURE:     phase_d = PH_SLOT;
          PH_SLOT:        phase_d = PH_SLOT_GUARD;
          PH_SLOT_GUARD:  phase_d = slots_done ? PH_START : PH_SLOT;
          default:        phase_d = PH_START;
        endcase
      end
    end
  end

  // Counters and masks
  always_comb begin
    tick_d       = tick_q;
    beacons_d    = beacons_q;
    slot_d       = slot_q;
    node_mask_d  = node_mask_q;
    shift_mask_d = shift_mask_q;
    if (tick) begin
      tick_d       = wait_end ? 16'd0 : tick_inc;
      beacons_d    = cur_beacons;
      slot_d       = cur_slot;
      node_mask_d  = cur_node_mask;
      shift_mask_d = cur_shift_mask;
      if (wait_end) begin
        case (cur_phase)
          PH_GUARD: beacons_d = beacons_inc;
          PH_MEASURE: begin
            slot_d       = '0;
            shift_mask_d = cur_shift_mask >> 1;
          end
          PH_SLOT_GUARD: begin
            if (!slots_done) begin
              slot_d       = slot_inc;
              shift_mask_d = cur_shift_mask >> 1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result of this tick
  logic       res_valid;
  logic       res_kind;
  logic [7:0] res_payload;
  logic [2:0] res_index;

  always_comb begin
    res_valid   = 1'b0;
    res_kind    = FRAME_BEACON;
    res_payload = cur_node_mask;
    res_index   = beacons_inc;
    if (tick && wait_end) begin
      case (cur_phase)
        PH_GUARD: res_valid = 1'b1;
        PH_MEASURE: begin
          res_valid   = cur_shift_mask[0];
          res_kind    = FRAME_POLL;
          res_payload = 8'd0;
          res_index   = 3'd0;
        end
        PH_SLOT_GUARD: begin
          res_valid   = cur_shift_mask[0] && !slots_done;
          res_kind    = FRAME_POLL;
          res_payload = {5'd0, slot_inc};
          res_index   = 3'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      tick_q       <= '0;
      beacons_q    <= '0;
      slot_q       <= '0;
      node_mask_q  <= '0;
      shift_mask_q <= '0;
    end else begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      beacons_q    <= beacons_d;
      slot_q       <= slot_d;
      node_mask_q  <= node_mask_d;
      shift_mask_q <= shift_mask_d;
    end
  end

  // Result register: load a new result, or drop the old one once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_kind_q    <= res_kind;
      out_payload_q <= res_payload;
      out_index_q   <= res_index;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {5'd0, out_index_q, out_payload_q};

  // A beacon always carries a nonzero number within the burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == FRAME_BEACON) |-> (m_axis_tdata_o[10:8] != 3'd0))
    else $error("beacon result with zero beacon index");

  // A poll carries a slot index inside the superframe and no beacon number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == FRAME_POLL)
      |-> (m_axis_tdata_o[10:8] == 3'd0 && {1'b0, m_axis_tdata_o[7:0]} < 9'(NODE_SLOTS)))
    else $error("poll result with bad slot or beacon index");

  // With the result register empty an input transaction is always taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // The wait counter is idle between superframes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_START) |-> (tick_q == 16'd0))
    else $error("tick counter running at superframe start");

endmodule

[tb/sv/tb_beacon_poll_superframe_sequencer.sv]
`timescale 1ns / 1ps
module tb_beacon_poll_superframe_sequencer;
  import bpss_pkg::*;

  localparam int NodeSlots   = 8;
  localparam int HoldOffLen  = 300;
  localparam int RandPhases  = 7;
  localparam int PhaseTicks  = 128;
  localparam int MaxPrinted  = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [2:0] bidx;
  } frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_ready_o;

  // Mirror of the sequencer state and its registers
  phase_e      sf_phase;
  logic [15:0] sf_ticks;
  logic [2:0]  sf_sent;
  logic [2:0]  sf_slot;
  logic [7:0]  sf_mask;
  logic [7:0]  sf_shift;
  cfg_t        sf_regs;

  frame_t      frames_due[$];
  int          errors = 0;
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;
  int          hold_cycles = 0;

  beacon_poll_superframe_sequencer #(
    .NODE_SLOTS(NodeSlots)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  task automatic flag_error(string what);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Count one tick of a wait; a zero limit behaves as one tick
  function automatic bit wait_elapsed(logic [15:0] limit);
    sf_ticks = sf_ticks + 16'd1;
    if (sf_ticks >= limit || sf_ticks == 16'd0) begin
      sf_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Open a polling slot: poll if the low mask bit is set, then shift
  function automatic bit open_slot(output frame_t fr);
    bit hit;
    hit = sf_shift[0];
    fr.kind = FRAME_POLL;
    fr.payload = {5'd0, sf_slot};
    fr.bidx = 3'd0;
    sf_shift = sf_shift >> 1;
    sf_phase = PH_SLOT;
    return hit;
  endfunction

  // Advance the superframe by one input transaction; returns 1 when a frame goes out
  function automatic bit sequence_tick(logic adv, logic [7:0] mask_in, output frame_t fr);
    bit hit;
    hit = 1'b0;
    fr = '0;
    if (!adv) return 1'b0;
    if (sf_phase == PH_START) begin
      sf_mask = mask_in;
      sf_shift = mask_in;
      sf_ticks = '0;
      sf_sent = '0;
      sf_slot = '0;
      sf_phase = PH_BEACON_WAIT;
    end
    case (sf_phase)
      PH_BEACON_WAIT: begin
        if (wait_elapsed(sf_regs.beacon_wait)) sf_phase = PH_GUARD;
      end
      PH_GUARD: begin
        if (wait_elapsed(sf_regs.guard)) begin
          sf_sent = sf_sent + 3'd1;
          fr.kind = FRAME_BEACON;
          fr.payload = sf_mask;
          fr.bidx = sf_sent;
          hit = 1'b1;
          if (sf_sent >= sf_regs.beacon_count || sf_sent == 3'd0) sf_phase = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (wait_elapsed(sf_regs.measure_wait)) begin
          sf_slot = '0;
          hit = open_slot(fr);
        end
      end
      PH_SLOT: begin
        if (wait_elapsed(sf_regs.slot)) sf_phase = PH_SLOT_GUARD;
      end
      PH_SLOT_GUARD: begin
        if (wait_elapsed(sf_regs.guard)) begin
          if (int'(sf_slot) + 1 >= NodeSlots) begin
            sf_phase = PH_START;
          end else begin
            sf_slot = sf_slot + 3'd1;
            hit = open_slot(fr);
          end
        end
      end
      default: sf_phase = PH_START;
    endcase
    return hit;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_BEACON_WAIT:  sf_regs.beacon_wait = val;
      CFG_GUARD:        sf_regs.guard = val;
      CFG_MEASURE_WAIT: sf_regs.measure_wait = val;
      CFG_SLOT:         sf_regs.slot = val;
      CFG_BEACON_COUNT: sf_regs.beacon_count = val[2:0];
      default: ;
    endcase
  endfunction

  // Track accepted transactions and check every delivered frame
  always @(posedge clk_i) begin
    frame_t got;
    frame_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        got.kind = m_axis_tuser_o;
        got.payload = m_axis_tdata_o[7:0];
        got.bidx = m_axis_tdata_o[10:8];
        if (frames_due.size() == 0) begin
          flag_error($sformatf("frame kind %0d payload %0h with nothing pending",
                               got.kind, got.payload));
        end else begin
          want = frames_due.pop_front();
          if (got.kind !== want.kind)
            flag_error($sformatf("frame_kind got %0d want %0d", got.kind, want.kind));
          if (got.payload !== want.payload)
            flag_error($sformatf("frame_payload got %0h want %0h", got.payload, want.payload));
          if (got.bidx !== want.bidx)
            flag_error($sformatf("beacon_index got %0d want %0d", got.bidx, want.bidx));
        end
      end
      if (cfg_valid && cfg_ready_o) apply_reg(cfg_addr, cfg_data);
      if (s_valid && s_axis_tready_o) begin
        if (sequence_tick(s_data[0], s_data[8:1], want)) frames_due.push_back(want);
      end
    end
  end

  function automatic int draw_gap(bit enabled);
    return enabled ? int'($urandom_range(0, 11)) : 0;
  endfunction

  // Result side: random stalls per frame, plus one long hold-off on request
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk_i);
        m_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = draw_gap(sink_idle);
      @(negedge clk_i);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Offer one tick transaction; tvalid stays high afterwards for back-to-back traffic
  task automatic send_tick(logic adv, logic [7:0] mask_in);
    int gap;
    gap = draw_gap(src_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {7'd0, mask_in, adv};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stop the input, let all pending frames out and the pipeline go quiet
  task automatic drain_results();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_wait();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(7, 20));
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  // Zero registers act as one tick and one beacon; full and empty masks;
  // idle transactions never latch a mask
  task automatic test_zero_registers();
    write_reg(CFG_BEACON_WAIT, 16'd0);
    write_reg(CFG_GUARD, 16'd0);
    write_reg(CFG_MEASURE_WAIT, 16'd0);
    write_reg(CFG_SLOT, 16'd0);
    write_reg(CFG_BEACON_COUNT, 16'hFFF8);
    send_tick(1'b0, 8'h5A);
    send_tick(1'b1, 8'hFF);
    for (int i = 0; i < 18; i++) send_tick(1'b1, 8'($urandom));
    send_tick(1'b0, 8'hFF);
    send_tick(1'b1, 8'h00);
    for (int i = 0; i < 18; i++) send_tick(1'b1, 8'($urandom));
    drain_results();
  endtask

  // Writes to unused indexes leave every register alone
  task automatic test_unused_index();
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'h0000);
    write_reg(3'd7, 16'($urandom));
    send_tick(1'b1, 8'h81);
    for (int i = 0; i < 6; i++) send_tick(1'b1, 8'($urandom));
    drain_results();
  endtask

  // Largest waits and beacon count; shorten a wait that has already run past its new end
  task automatic test_wait_shortened();
    write_reg(CFG_BEACON_WAIT, 16'hFFFF);
    write_reg(CFG_GUARD, 16'hFFFF);
    write_reg(CFG_MEASURE_WAIT, 16'hFFFF);
    write_reg(CFG_SLOT, 16'hFFFF);
    write_reg(CFG_BEACON_COUNT, 16'd7);
    for (int i = 0; i < 16; i++) send_tick(1'b1, 8'($urandom));
    drain_results();
    write_reg(CFG_BEACON_WAIT, 16'd2);
    write_reg(CFG_GUARD, 16'd2);
    for (int i = 0; i < 8; i++) send_tick(1'b1, 8'($urandom));
    drain_results();
    write_reg(CFG_MEASURE_WAIT, 16'd1);
    write_reg(CFG_SLOT, 16'd1);
    drain_results();
  endtask

  // Random settings and traffic, mostly ticks with some idle transactions
  task automatic test_random_traffic();
    for (int p = 0; p < RandPhases; p++) begin
      drain_results();
      write_reg(CFG_BEACON_WAIT, rand_wait());
      write_reg(CFG_GUARD, rand_wait());
      write_reg(CFG_MEASURE_WAIT, rand_wait());
      write_reg(CFG_SLOT, rand_wait());
      write_reg(CFG_BEACON_COUNT, 16'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      src_idle = (p != 0) && ($urandom_range(0, 2) != 0);
      sink_idle = (p != 0) && ($urandom_range(0, 2) != 0);
      for (int i = 0; i < PhaseTicks; i++) begin
        send_tick(1'($urandom_range(0, 9) != 0), 8'($urandom));
      end
    end
    drain_results();
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Hold the result side off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(CFG_BEACON_WAIT, 16'd1);
    write_reg(CFG_GUARD, 16'd1);
    write_reg(CFG_MEASURE_WAIT, 16'd1);
    write_reg(CFG_SLOT, 16'd1);
    write_reg(CFG_BEACON_COUNT, 16'd7);
    src_idle = 1'b0;
    hold_cycles = HoldOffLen;
    for (int i = 0; i < 80; i++) send_tick(1'b1, 8'($urandom));
    src_idle = 1'b1;
    drain_results();
  endtask

  initial begin
    sf_phase = PH_START;
    sf_ticks = '0;
    sf_sent = '0;
    sf_slot = '0;
    sf_mask = '0;
    sf_shift = '0;
    sf_regs.beacon_wait = RST_BEACON_WAIT;
    sf_regs.guard = RST_GUARD;
    sf_regs.measure_wait = RST_MEASURE_WAIT;
    sf_regs.slot = RST_SLOT;
    sf_regs.beacon_count = RST_BEACON_COUNT;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // A few ticks under the reset settings before anything is written
    for (int i = 0; i < 5; i++) send_tick(1'b1, 8'($urandom));
    drain_results();

    test_zero_registers();
    test_unused_index();
    test_wait_shortened();
    test_backpressure();
    test_random_traffic();

    @(negedge clk_i);
    s_valid <= 1'b0;
    for (int i = 0; i < 2000 && frames_due.size() != 0; i++) @(posedge clk_i);
    if (frames_due.size() != 0) begin
      flag_error($sformatf("%0d frames never delivered", frames_due.size()));
    end
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("beacon_poll_superframe_sequencer: match");
    end else begin
      $display("beacon_poll_superframe_sequencer: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("beacon_poll_superframe_sequencer: mismatch");
    $finish;
  end

endmodule
